// File: hw/rtl/afmf_pkg.sv
// Shared constants, types and codes of the address filtered message FIFO.
package afmf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MSG_BYTES   = 32;
    localparam int TIME_BITS   = 32;

    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W     = $clog2(MSG_BYTES + 1);
    localparam int POS_W     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int PAY_DEPTH = QUEUE_DEPTH * MSG_BYTES;
    localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;
    localparam int STAMP_W   = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int META_W    = LEN_W + STAMP_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 1'd1;

    typedef enum logic [2:0] {
        KIND_ACCEPTED,
        KIND_CLOSED,
        KIND_MISMATCH,
        KIND_FULL,
        KIND_POP_EMPTY,
        KIND_POP_BYTE
    } kind_t;

    typedef enum logic [1:0] {
        DROP_KEEP,
        DROP_CLOSED,
        DROP_MISMATCH,
        DROP_FULL
    } drop_t;

    typedef enum logic {
        ACT_PUSH,
        ACT_POP
    } action_t;

    typedef struct packed {
        logic push;
        logic pop_start;
        logic pop_empty;
        logic load_byte;
    } afmf_cmd_t;

    typedef struct packed {
        logic empty;
        logic out_free;
        logic stream_last;
    } afmf_status_t;

endpackage

// File: hw/rtl/afmf_ifs.sv
// Handshake channel interfaces: request, response and configuration write.
interface afmf_req_if
    import afmf_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  bus_address;
    logic [7:0]  data_byte;
    logic        byte_last;
    logic [31:0] arrival_time;

    modport source (output valid, action, bus_address, data_byte, byte_last, arrival_time,
                    input ready);
    modport sink (input valid, action, bus_address, data_byte, byte_last, arrival_time,
                  output ready);
endinterface

interface afmf_rsp_if
    import afmf_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [5:0]  msg_length;
    logic [31:0] msg_time;
    logic [7:0]  byte_value;
    logic [4:0]  byte_index;
    logic        last_of_run;

    modport source (output valid, result_kind, msg_length, msg_time, byte_value, byte_index,
                    last_of_run, input ready);
    modport sink (input valid, result_kind, msg_length, msg_time, byte_value, byte_index,
                  last_of_run, output ready);
endinterface

interface afmf_cfg_if
    import afmf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/afmf_ram.sv
// Generic simple dual-port RAM with registered read data.
module afmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/afmf_ctrl.sv
// Controller: accepts request transactions and sequences the message stream.
module afmf_ctrl
    import afmf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_action,
    output logic         in_ready,
    input  afmf_status_t status,
    output afmf_cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    always_comb
    begin
        in_ready      = (state_reg == S_IDLE) && status.out_free;
        take          = in_valid && in_ready;
        cmd.push      = take && (in_action == ACT_PUSH);
        cmd.pop_empty = take && (in_action == ACT_POP) && status.empty;
        cmd.pop_start = take && (in_action == ACT_POP) && !status.empty;
        cmd.load_byte = (state_reg == S_STREAM) && status.out_free;
        state_next    = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.pop_start)
                begin
                    state_next = S_STREAM;
                end
            end
            S_STREAM:
            begin
                if (cmd.load_byte && status.stream_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/afmf_datapath.sv
// Datapath: ring indices, frame verdict, message stores and result register.
module afmf_datapath
    import afmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  afmf_cmd_t            cmd,
    output afmf_status_t         status,
    input  logic [7:0]           bus_address,
    input  logic [7:0]           data_byte,
    input  logic                 byte_last,
    input  logic [31:0]          arrival_time,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           result_kind,
    output logic [5:0]           msg_length,
    output logic [31:0]          msg_time,
    output logic [7:0]           byte_value,
    output logic [4:0]           byte_index,
    output logic                 last_of_run
);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    logic              listen_reg, listen_next;
    logic [7:0]        own_reg, own_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              active_reg, active_next;
    drop_t             drop_reg, drop_next;
    logic              out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]  fill_len_reg, fill_len_next;
    logic [SLOT_W-1:0] stream_slot_reg, stream_slot_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    kind_t             kind_reg, kind_next;
    logic [5:0]        len_reg, len_next;
    logic [31:0]       time_reg, time_next;
    logic [7:0]        byte_reg, byte_next;
    logic [4:0]        idx_reg, idx_next;
    logic              last_reg, last_next;

    logic              pay_we, pay_re;
    logic [PAY_AW-1:0] pay_waddr, pay_raddr;
    logic [7:0]        pay_rdata;
    logic              meta_we, meta_re;
    logic [META_W-1:0] meta_wdata, meta_rdata;
    logic [LEN_W-1:0]  meta_len;
    logic [STAMP_W-1:0] meta_stamp;

    drop_t             verdict, drop_cur;
    logic [LEN_W-1:0]  fill_pos, fill_len_new;
    logic              keep, room, out_free;

    assign meta_len   = meta_rdata[META_W-1 -: LEN_W];
    assign meta_stamp = meta_rdata[STAMP_W-1:0];
    assign out_free   = !out_valid_reg || out_ready;

    assign status.empty       = (count_reg == '0);
    assign status.out_free    = out_free;
    assign status.stream_last = ((LEN_W'(pos_reg) + LEN_W'(1)) == meta_len);

    always_comb
    begin
        if (!listen_reg)
        begin
            verdict = DROP_CLOSED;
        end
        else if (bus_address != own_reg)
        begin
            verdict = DROP_MISMATCH;
        end
        else if (count_reg == CNT_W'(QUEUE_DEPTH))
        begin
            verdict = DROP_FULL;
        end
        else
        begin
            verdict = DROP_KEEP;
        end
        drop_cur     = active_reg ? drop_reg : verdict;
        fill_pos     = active_reg ? fill_len_reg : '0;
        keep         = (drop_cur == DROP_KEEP);
        room         = (fill_pos < LEN_W'(MSG_BYTES));
        fill_len_new = room ? (fill_pos + LEN_W'(1)) : fill_pos;

        listen_next      = listen_reg;
        own_next         = own_reg;
        rd_idx_next      = rd_idx_reg;
        wr_idx_next      = wr_idx_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        drop_next        = drop_reg;
        fill_len_next    = fill_len_reg;
        stream_slot_next = stream_slot_reg;
        pos_next         = pos_reg;
        kind_next        = kind_reg;
        len_next         = len_reg;
        time_next        = time_reg;
        byte_next        = byte_reg;
        idx_next         = idx_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        pay_we     = 1'b0;
        pay_waddr  = PAY_AW'(wr_idx_reg * MSG_BYTES + POS_W'(fill_pos));
        pay_re     = 1'b0;
        pay_raddr  = PAY_AW'(rd_idx_reg * MSG_BYTES);
        meta_we    = 1'b0;
        meta_re    = 1'b0;
        meta_wdata = {fill_len_new, STAMP_W'(arrival_time)};

        if (cmd.push)
        begin
            pay_we        = keep && room;
            fill_len_next = fill_len_new;
            if (byte_last)
            begin
                if (keep)
                begin
                    meta_we     = 1'b1;
                    wr_idx_next = slot_inc(wr_idx_reg);
                    count_next  = count_reg + CNT_W'(1);
                end
                out_valid_next = 1'b1;
                kind_next      = kind_t'({1'b0, drop_cur});
                len_next       = '0;
                time_next      = '0;
                byte_next      = '0;
                idx_next       = '0;
                last_next      = 1'b1;
                active_next    = 1'b0;
                drop_next      = DROP_KEEP;
            end
            else
            begin
                active_next = 1'b1;
                drop_next   = drop_cur;
            end
        end

        if (cmd.pop_empty)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_POP_EMPTY;
            len_next       = '0;
            time_next      = '0;
            byte_next      = '0;
            idx_next       = '0;
            last_next      = 1'b1;
        end

        if (cmd.pop_start)
        begin
            meta_re          = 1'b1;
            pay_re           = 1'b1;
            stream_slot_next = rd_idx_reg;
            pos_next         = '0;
            rd_idx_next      = slot_inc(rd_idx_reg);
            count_next       = count_reg - CNT_W'(1);
        end

        if (cmd.load_byte)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_POP_BYTE;
            len_next       = 6'(meta_len);
            time_next      = 32'(meta_stamp);
            byte_next      = pay_rdata;
            idx_next       = 5'(pos_reg);
            last_next      = status.stream_last;
            if (!status.stream_last)
            begin
                pos_next  = POS_W'(pos_reg + POS_W'(1));
                pay_re    = 1'b1;
                pay_raddr = PAY_AW'(stream_slot_reg * MSG_BYTES + pos_reg + 1);
            end
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LISTEN:
                begin
                    listen_next = cfg_data[0];
                end
                CFG_OWN_ADDR:
                begin
                    own_next    = cfg_data;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    count_next  = '0;
                    if (active_next && (drop_next == DROP_KEEP))
                    begin
                        drop_next = DROP_MISMATCH;
                    end
                end
                default:
                begin
                    listen_next = listen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_reg    <= 1'b0;
            own_reg       <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            drop_reg      <= DROP_KEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            listen_reg    <= listen_next;
            own_reg       <= own_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_len_reg    <= fill_len_next;
        stream_slot_reg <= stream_slot_next;
        pos_reg         <= pos_next;
        kind_reg        <= kind_next;
        len_reg         <= len_next;
        time_reg        <= time_next;
        byte_reg        <= byte_next;
        idx_reg         <= idx_next;
        last_reg        <= last_next;
    end

    afmf_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (data_byte),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    afmf_ram #(
        .WIDTH (META_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (wr_idx_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (rd_idx_reg),
        .rdata (meta_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign msg_length  = len_reg;
    assign msg_time    = time_reg;
    assign byte_value  = byte_reg;
    assign byte_index  = idx_reg;
    assign last_of_run = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("message count above ring depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_start |-> (count_reg != '0))
        else $error("stream started on empty ring");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        meta_we |-> (count_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("frame committed into full ring");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_byte |-> out_free)
        else $error("result register overwritten while held");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_start && !cfg_valid) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not retire one message");

endmodule

// File: hw/rtl/address_filtered_message_fifo_unit.sv
// Top level of the address filtered message FIFO: channels, controller and datapath.
//
// Request channel req carries one transaction per push byte or pop. Bytes of a frame
// may arrive back to back. The first byte fixes the verdict (listen enable, address
// match, room in the ring); the last byte commits the frame with its timestamp and
// returns one status result.
// A pop on an empty ring returns one empty result. A pop of a stored message reads its
// length, timestamp and first byte from the RAMs, then streams one result per payload
// byte, one per cycle while the result register is free, through the payload RAM read
// port; the request channel is closed until the last byte is in the result register.
// Results leave through the result register on rsp. A status or empty result is there
// in the cycle after its transaction, the first byte of a pop after the RAM read. When the
// receiver stalls, the result holds and the block stops taking requests and streaming
// until the register frees.
// Configuration writes on cfg are always ready; writing own_address flushes the ring.
// Reset empties the ring, clears listen enable and own address; no clearing pass.
module address_filtered_message_fifo_unit
    import afmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    afmf_req_if.sink   req,
    afmf_rsp_if.source rsp,
    afmf_cfg_if.sink   cfg
);

    afmf_cmd_t    cmd;
    afmf_status_t status;

    assign cfg.ready = 1'b1;

    afmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_action (req.action),
        .in_ready  (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    afmf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .bus_address  (req.bus_address),
        .data_byte    (req.data_byte),
        .byte_last    (req.byte_last),
        .arrival_time (req.arrival_time),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .result_kind  (rsp.result_kind),
        .msg_length   (rsp.msg_length),
        .msg_time     (rsp.msg_time),
        .byte_value   (rsp.byte_value),
        .byte_index   (rsp.byte_index),
        .last_of_run  (rsp.last_of_run)
    );

endmodule
